@@ hw/rtl/kmp_pkg.sv @@
`timescale 1ns / 1ps

package kmp_pkg;

  // Pattern store geometry
  localparam int MAX_PATTERN = 64;
  localparam int ALPHABET    = 26;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int LETTER_W    = 5;
  localparam int CMD_W       = 2;
  localparam int CNT_W       = 32;

  // Item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_TEXT    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

endpackage

@@ hw/rtl/kmp_ram.sv @@
`timescale 1ns / 1ps

module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/kmp_stream_matcher.sv @@
`timescale 1ns / 1ps

// Streaming KMP matcher over a 26-letter alphabet.
// An item (in_cmd, in_letter) is taken on a rising edge with start high and
// busy low. Commands: clear pattern/position/count, append a pattern letter,
// feed a text letter, reset the match position only.
// Every item yields one result on the out_ ports, valid for exactly one cycle
// while out_strobe is high; the receiver cannot hold it off.
// Pattern letters and failure links sit in two 64-entry synchronous RAMs.
// Clear, restart, dropped or first appends and text on an empty pattern
// finish in the accept cycle: the result shows the cycle after.
// Appends and text letters walk failure links, one RAM read per cycle;
// the result shows in the cycle after the last step. busy is high during
// the walk. KMP amortizes the links visited to at most one per text
// letter; a single letter may visit up to one less than the current
// pattern length.
// Reset (rst_n low, synchronous) empties the pattern and zeros the position
// and the count; RAM contents are not cleared and need no pass.
module kmp_stream_matcher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [kmp_pkg::CMD_W-1:0]     in_cmd,
  input  logic [kmp_pkg::LETTER_W-1:0]  in_letter,
  output logic                          out_strobe,
  output logic                          out_matched,
  output logic [kmp_pkg::CNT_W-1:0]     out_match_total,
  output logic [kmp_pkg::LEN_W-1:0]     out_position,
  output logic                          out_overflow
);
  import kmp_pkg::*;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [LETTER_W-1:0]   let_r, let_nxt;
  logic [IDX_W-1:0]      j_r, j_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [LEN_W-1:0]      pos_r, pos_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      last_fail_r, last_fail_nxt;
  logic                  strobe_r, strobe_nxt;
  logic                  matched_r, matched_nxt;
  logic                  overflow_r, overflow_nxt;

  logic                  accept;
  logic                  hit;
  logic [LEN_W-1:0]      fin;
  logic [CNT_W-1:0]      cnt_inc;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [LETTER_W-1:0]   pat_wdata, pat_rdata;
  logic [IDX_W-1:0]      fail_wdata, fail_rdata;

  // Pattern letters: entry i holds pattern[i]
  kmp_ram #(.WIDTH(LETTER_W), .DEPTH(MAX_PATTERN)) u_pat_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (pat_wdata),
    .raddr (j_nxt),
    .rdata (pat_rdata)
  );

  // Failure links: entry i holds the border length of prefix i+1
  kmp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PATTERN)) u_fail_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (fail_wdata),
    .raddr (j_nxt - 1'b1),
    .rdata (fail_rdata)
  );

  assign accept  = start && (state_r == ST_IDLE);
  assign hit     = (pat_rdata == let_r) && (let_r < LETTER_W'(ALPHABET));
  assign fin     = LEN_W'(j_r) + LEN_W'(hit);
  assign cnt_inc = (cnt_r != '1) ? cnt_r + 1'b1 : cnt_r;

  // Next state, RAM access and result
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    let_nxt       = let_r;
    j_nxt         = j_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    last_fail_nxt = last_fail_r;
    strobe_nxt    = 1'b0;
    matched_nxt   = 1'b0;
    overflow_nxt  = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = len_r[IDX_W-1:0];
    pat_wdata     = let_r;
    fail_wdata    = fin[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt = cmd_t'(in_cmd);
          let_nxt = in_letter;
          unique case (cmd_t'(in_cmd))
            CMD_CLEAR: begin
              len_nxt    = '0;
              pos_nxt    = '0;
              cnt_nxt    = '0;
              strobe_nxt = 1'b1;
            end
            CMD_RESTART: begin
              pos_nxt    = '0;
              strobe_nxt = 1'b1;
            end
            CMD_APPEND: begin
              priority if (len_r == LEN_W'(MAX_PATTERN)) begin
                overflow_nxt = 1'b1;
                strobe_nxt   = 1'b1;
              end else if (in_letter >= LETTER_W'(ALPHABET)) begin
                strobe_nxt = 1'b1;
              end else if (len_r == '0) begin
                // first letter: border is empty
                ram_we        = 1'b1;
                ram_waddr     = '0;
                pat_wdata     = in_letter;
                fail_wdata    = '0;
                len_nxt       = LEN_W'(1);
                last_fail_nxt = '0;
                strobe_nxt    = 1'b1;
              end else begin
                j_nxt     = last_fail_r;
                state_nxt = ST_WALK;
              end
            end
            CMD_TEXT: begin
              if (len_r == '0) begin
                // empty pattern matches every letter
                pos_nxt     = '0;
                matched_nxt = 1'b1;
                cnt_nxt     = cnt_inc;
                strobe_nxt  = 1'b1;
              end else begin
                j_nxt     = (pos_r >= len_r) ? last_fail_r : pos_r[IDX_W-1:0];
                state_nxt = ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if ((j_r != '0) && !hit) begin
          // follow the failure link, read issued this cycle
          j_nxt = fail_rdata;
        end else begin
          state_nxt  = ST_IDLE;
          strobe_nxt = 1'b1;
          if (cmd_r == CMD_APPEND) begin
            ram_we        = 1'b1;
            len_nxt       = len_r + 1'b1;
            last_fail_nxt = fin[IDX_W-1:0];
          end else begin
            pos_nxt = fin;
            if (fin == len_r) begin
              matched_nxt = 1'b1;
              cnt_nxt     = cnt_inc;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      len_r    <= '0;
      pos_r    <= '0;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    let_r       <= let_nxt;
    j_r         <= j_nxt;
    last_fail_r <= last_fail_nxt;
    matched_r   <= matched_nxt;
    overflow_r  <= overflow_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_strobe      = strobe_r;
  assign out_matched     = strobe_r && matched_r;
  assign out_overflow    = strobe_r && overflow_r;
  assign out_match_total = cnt_r;
  assign out_position    = pos_r;

  // Matched prefix never exceeds the pattern
  a_pos_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= len_r)
    else $error("position beyond pattern length");

  // A walk only runs on a non-empty pattern and inside it
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> (len_r != '0) && (LEN_W'(j_r) < len_r))
    else $error("walk index outside pattern");

  // Each result follows an accepted item or the end of a walk
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> $past(accept || state_r == ST_WALK))
    else $error("result without item");

  // Overflow flagged only when the store is full
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_overflow |-> len_r == LEN_W'(MAX_PATTERN))
    else $error("overflow with room left");

  // A match on a non-empty pattern ends at its full length
  a_match_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_matched && (len_r != '0) |-> pos_r == len_r)
    else $error("match short of pattern length");

endmodule

@@ verif/tb_kmp_stream_matcher.sv @@
`timescale 1ns / 1ps

module tb_kmp_stream_matcher;
  import kmp_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int RANDOM_ITEMS = 750;

  // One result as the block reports it
  typedef struct {
    logic             matched;
    logic [CNT_W-1:0] total;
    logic [LEN_W-1:0] position;
    logic             overflow;
  } match_report_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  cmd_t                in_cmd = CMD_CLEAR;
  logic [LETTER_W-1:0] in_letter = '0;
  logic                busy;
  logic                out_strobe;
  logic                out_matched;
  logic [CNT_W-1:0]    out_match_total;
  logic [LEN_W-1:0]    out_position;
  logic                out_overflow;

  // Shadow of the matcher state
  logic [LETTER_W-1:0] letter_mem [MAX_PATTERN] = '{default: '0};
  int                  link_mem [MAX_PATTERN] = '{default: 0};
  int                  pat_len = 0;
  int                  cur_pos = 0;
  logic [CNT_W-1:0]    hit_count = '0;

  match_report_t match_reports_q[$];
  match_report_t got_r;
  match_report_t exp_r;
  int            mismatches = 0;
  int            cycles = 0;
  int            items_sent = 0;
  int            idle_pct = 0;
  int            last_base = 0;
  int            last_span = 1;

  kmp_stream_matcher u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_letter       (in_letter),
    .out_strobe      (out_strobe),
    .out_matched     (out_matched),
    .out_match_total (out_match_total),
    .out_position    (out_position),
    .out_overflow    (out_overflow)
  );

  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Walk failure links from prefix length j for letter c
  function automatic int follow_link(int j, logic [LETTER_W-1:0] c);
    while (j > 0 && j < MAX_PATTERN && letter_mem[j] != c)
      j = link_mem[j-1];
    if (j < MAX_PATTERN && letter_mem[j] == c && c < ALPHABET)
      j++;
    return j;
  endfunction

  function automatic void count_hit();
    if (hit_count != '1)
      hit_count++;
  endfunction

  // Update the shadow state for one accepted item and queue its report
  function automatic void predict_match(cmd_t cmd, logic [LETTER_W-1:0] letter);
    match_report_t r;
    int j;
    r.matched = 1'b0;
    r.overflow = 1'b0;
    case (cmd)
      CMD_CLEAR: begin
        pat_len = 0;
        cur_pos = 0;
        hit_count = '0;
      end
      CMD_APPEND: begin
        if (pat_len >= MAX_PATTERN) begin
          r.overflow = 1'b1;
        end else if (letter < ALPHABET) begin
          j = 0;
          if (pat_len > 0)
            j = follow_link(link_mem[pat_len-1], letter);
          letter_mem[pat_len] = letter;
          link_mem[pat_len] = j;
          pat_len++;
        end
      end
      CMD_TEXT: begin
        if (pat_len == 0) begin
          cur_pos = 0;
          r.matched = 1'b1;
          count_hit();
        end else begin
          j = cur_pos;
          // a full match first falls back along the last link
          if (j >= pat_len)
            j = link_mem[pat_len-1];
          j = follow_link(j, letter);
          cur_pos = j;
          if (j == pat_len) begin
            r.matched = 1'b1;
            count_hit();
          end
        end
      end
      default: begin
        cur_pos = 0;
      end
    endcase
    r.total = hit_count;
    r.position = LEN_W'(cur_pos);
    match_reports_q.insert(match_reports_q.size(), r);
  endfunction

  // Result checker: the receiver never stalls
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      got_r.matched = out_matched;
      got_r.total = out_match_total;
      got_r.position = out_position;
      got_r.overflow = out_overflow;
      if (match_reports_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: matched=%0d total=%0d pos=%0d ovf=%0d",
                   got_r.matched, got_r.total, got_r.position, got_r.overflow);
      end else begin
        exp_r = match_reports_q.pop_front();
        if (got_r.matched !== exp_r.matched || got_r.total !== exp_r.total ||
            got_r.position !== exp_r.position || got_r.overflow !== exp_r.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp matched=%0d total=%0d pos=%0d ovf=%0d, got %0d %0d %0d %0d",
                     exp_r.matched, exp_r.total, exp_r.position, exp_r.overflow,
                     got_r.matched, got_r.total, got_r.position, got_r.overflow);
        end
      end
    end
  end

  // Send one item; start stays high unless a gap is taken
  task automatic send_item(cmd_t cmd, logic [LETTER_W-1:0] letter);
    // insert random idle gaps at the current rate
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_letter <= letter;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_match(cmd, letter);
    items_sent++;
  endtask

  // Hold off until every pending report has arrived
  task automatic wait_reports_drained(int settle);
    start <= 1'b0;
    while (match_reports_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [LETTER_W-1:0] pick_letter(int base, int span);
    if ($urandom_range(99) < 5)
      return LETTER_W'($urandom_range(31));
    return LETTER_W'(base + $urandom_range(span - 1));
  endfunction

  // Directed: every command and the corner cases
  task automatic test_commands();
    idle_pct = 24;
    send_item(CMD_TEXT, 5'd0);        // empty pattern matches anything
    send_item(CMD_TEXT, 5'd31);
    send_item(CMD_RESTART, 5'd0);
    send_item(CMD_APPEND, 5'd31);     // outside the alphabet: dropped
    send_item(CMD_APPEND, 5'd26);
    send_item(CMD_APPEND, 5'd0);      // pattern "aba"
    send_item(CMD_APPEND, 5'd1);
    send_item(CMD_APPEND, 5'd0);
    send_item(CMD_TEXT, 5'd0);        // "ababa": two overlapping hits
    send_item(CMD_TEXT, 5'd1);
    send_item(CMD_TEXT, 5'd0);
    send_item(CMD_TEXT, 5'd1);
    send_item(CMD_TEXT, 5'd0);
    send_item(CMD_APPEND, 5'd25);     // grow pattern mid-text, position kept
    send_item(CMD_TEXT, 5'd25);
    send_item(CMD_TEXT, 5'd30);       // non-letter drops position to zero
    send_item(CMD_TEXT, 5'd0);
    send_item(CMD_TEXT, 5'd1);
    send_item(CMD_RESTART, 5'd0);
    send_item(CMD_CLEAR, 5'd0);
    send_item(CMD_APPEND, 5'd16);
    send_item(CMD_TEXT, 5'd16);
    send_item(CMD_TEXT, 5'd25);
    wait_reports_drained(8);
  endtask

  // Fill the store, overflow it, and run long link walks
  task automatic test_store_full();
    logic [LETTER_W-1:0] pat [MAX_PATTERN];
    idle_pct = 47;
    for (int round = 0; round < 2; round++) begin
      send_item(CMD_CLEAR, 5'd0);
      for (int i = 0; i < MAX_PATTERN; i++) begin
        pat[i] = (round == 0 || $urandom_range(99) < 80) ? 5'd0 : 5'd1;
        send_item(CMD_APPEND, pat[i]);
      end
      send_item(CMD_APPEND, 5'd1);
      send_item(CMD_APPEND, 5'd31);
      if (round == 0) begin
        repeat (100) send_item(CMD_TEXT, ($urandom_range(99) < 6) ? 5'd1 : 5'd0);
      end else begin
        repeat (2)
          for (int i = 0; i < MAX_PATTERN; i++) send_item(CMD_TEXT, pat[i]);
        repeat (40) send_item(CMD_TEXT, LETTER_W'($urandom_range(1)));
      end
    end
    wait_reports_drained(8);
  endtask

  // Random: mostly pattern-then-text sequences, some noise
  task automatic test_random(int n_items);
    logic [LETTER_W-1:0] pat [MAX_PATTERN];
    int first;
    int roll;
    int plen;
    int tlen;
    first = items_sent;
    while (items_sent - first < n_items) begin
      if (items_sent - first < n_items / 3)
        idle_pct = 24;
      else if (items_sent - first < 2 * n_items / 3)
        idle_pct = 47;
      else
        idle_pct = 0;
      roll = $urandom_range(99);
      if (roll < 15) begin
        repeat ($urandom_range(1, 8))
          send_item(cmd_t'($urandom_range(3)), LETTER_W'($urandom_range(31)));
      end else if (roll < 25) begin
        // reuse the current pattern
        send_item(CMD_RESTART, LETTER_W'($urandom_range(31)));
        repeat ($urandom_range(4, 30)) send_item(CMD_TEXT, pick_letter(last_base, last_span));
      end else begin
        last_span = $urandom_range(1, 3);
        last_base = $urandom_range(0, ALPHABET - last_span);
        plen = (roll < 31) ? $urandom_range(20, MAX_PATTERN) : $urandom_range(1, 6);
        send_item(CMD_CLEAR, LETTER_W'($urandom_range(31)));
        for (int i = 0; i < plen; i++) begin
          pat[i] = LETTER_W'(last_base + $urandom_range(last_span - 1));
          send_item(CMD_APPEND, pat[i]);
        end
        if (plen > 6)
          for (int i = 0; i < plen; i++) send_item(CMD_TEXT, pat[i]);
        tlen = $urandom_range(4, 30);
        for (int i = 0; i < tlen; i++) begin
          roll = $urandom_range(99);
          if (roll < 4)
            send_item(CMD_RESTART, LETTER_W'($urandom_range(31)));
          else if (roll < 9)
            send_item(CMD_APPEND, LETTER_W'(last_base + $urandom_range(last_span - 1)));
          else
            send_item(CMD_TEXT, pick_letter(last_base, last_span));
        end
      end
      // occasional full drain
      if ($urandom_range(99) < 4)
        wait_reports_drained(4);
    end
    wait_reports_drained(8);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_commands();
    test_store_full();
    test_random(RANDOM_ITEMS);
    wait_reports_drained(100);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
